// ===== design/ssel_pkg.sv =====
`timescale 1ns / 1ps
package ssel_pkg;

  localparam int MAX_PER_LINE = 10;
  localparam int CNT_W        = $clog2(MAX_PER_LINE + 1);
  localparam int IDX_W        = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

  // queue between front and back; depth must stay a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [8:0] LINE_OFFSET  = 9'd16;
  localparam logic [8:0] HEIGHT_SHORT = 9'd8;
  localparam logic [8:0] HEIGHT_TALL  = 9'd16;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] tile;
    logic [7:0] x;
    logic [7:0] y;
  } entry_t;

  typedef struct packed {
    logic   hit;
    logic   last;
    entry_t ent;
  } q_item_t;

endpackage

// ===== design/ssel_if.sv =====
`timescale 1ns / 1ps
interface ssel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sprite_y;
  logic [7:0] sprite_x;
  logic [7:0] tile_number;
  logic [7:0] attribute_bits;
  logic [7:0] scan_line;
  logic       last_entry;

  modport source (
    output valid, sprite_y, sprite_x, tile_number, attribute_bits, scan_line, last_entry,
    input  ready
  );
  modport sink (
    input  valid, sprite_y, sprite_x, tile_number, attribute_bits, scan_line, last_entry,
    output ready
  );
endinterface

interface ssel_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] out_y;
  logic [7:0] out_x;
  logic [7:0] out_tile;
  logic [7:0] out_attr;
  logic       last_result;

  modport source (
    output valid, found, out_y, out_x, out_tile, out_attr, last_result,
    input  ready
  );
  modport sink (
    input  valid, found, out_y, out_x, out_tile, out_attr, last_result,
    output ready
  );
endinterface

// ===== design/ssel_front.sv =====
`timescale 1ns / 1ps
module ssel_front (
  ssel_in_if.sink          in_ch,
  input  logic             tall_sprites,
  input  logic             q_full,
  output logic             q_push,
  output ssel_pkg::q_item_t q_item
);

  logic [8:0] probe;
  logic [8:0] y_ext;
  logic [8:0] height;
  logic       hit;

  assign probe  = {1'b0, in_ch.scan_line} + ssel_pkg::LINE_OFFSET;
  assign y_ext  = {1'b0, in_ch.sprite_y};
  assign height = tall_sprites ? ssel_pkg::HEIGHT_TALL : ssel_pkg::HEIGHT_SHORT;
  assign hit    = (probe >= y_ext) && (probe < (y_ext + height));

  assign in_ch.ready = !q_full;

  // misses that do not close the scan have no effect, so they are dropped here
  assign q_push = in_ch.valid && !q_full && (hit || in_ch.last_entry);

  always_comb begin
    q_item.hit      = hit;
    q_item.last     = in_ch.last_entry;
    q_item.ent.attr = in_ch.attribute_bits;
    q_item.ent.tile = in_ch.tile_number;
    q_item.ent.x    = in_ch.sprite_x;
    q_item.ent.y    = in_ch.sprite_y;
  end

endmodule

// ===== design/ssel_fifo.sv =====
`timescale 1ns / 1ps
module ssel_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssel_pkg::q_item_t push_item,
  output logic              full,
  output logic              q_valid,
  input  logic              pop,
  output ssel_pkg::q_item_t pop_item
);

  ssel_pkg::q_item_t                mem_r [ssel_pkg::Q_DEPTH];
  logic [ssel_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ssel_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ssel_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                             do_pop;

  assign full     = (cnt_r == ssel_pkg::Q_CNT_W'(ssel_pkg::Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];
  assign do_pop   = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/ssel_back.sv =====
`timescale 1ns / 1ps
module ssel_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ssel_pkg::q_item_t q_item,
  output logic              q_pop,
  ssel_out_if.source        out_ch
);

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  state_t                          state_r;
  ssel_pkg::entry_t                list_r   [ssel_pkg::MAX_PER_LINE];
  ssel_pkg::entry_t                list_nxt [ssel_pkg::MAX_PER_LINE];
  logic [ssel_pkg::CNT_W-1:0]      count_r;
  logic [ssel_pkg::IDX_W-1:0]      idx_r;
  logic [ssel_pkg::MAX_PER_LINE-1:0] keep;
  logic                            out_valid_r;
  logic                            found_r;
  logic                            last_r;
  ssel_pkg::entry_t                out_ent_r;
  logic                            insert;
  logic                            out_free;
  logic                            emit_last;
  ssel_pkg::entry_t                emit_ent;

  assign q_pop    = (state_r == ST_COLLECT);
  assign out_free = !out_valid_r || out_ch.ready;
  assign insert   = q_pop && q_valid && q_item.hit &&
                    (count_r < ssel_pkg::CNT_W'(ssel_pkg::MAX_PER_LINE));

  // keep[i]: slot i holds an entry whose X does not exceed the new one; the list
  // is sorted, so these form a prefix and the new entry lands right after it
  always_comb begin
    for (int i = 0; i < ssel_pkg::MAX_PER_LINE; i++) begin
      keep[i] = (ssel_pkg::CNT_W'(i) < count_r) && (list_r[i].x <= q_item.ent.x);
    end
    list_nxt[0] = keep[0] ? list_r[0] : q_item.ent;
    for (int i = 1; i < ssel_pkg::MAX_PER_LINE; i++) begin
      if (keep[i]) begin
        list_nxt[i] = list_r[i];
      end else if (keep[i-1]) begin
        list_nxt[i] = q_item.ent;
      end else begin
        list_nxt[i] = list_r[i-1];
      end
    end
  end

  assign emit_ent  = list_r[idx_r];
  assign emit_last = (count_r == '0) ||
                     (ssel_pkg::CNT_W'(idx_r) == ssel_pkg::CNT_W'(count_r - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_COLLECT: begin
          if (q_valid) begin
            if (insert) begin
              count_r <= count_r + 1'b1;
            end
            if (q_item.last) begin
              idx_r   <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (emit_last) begin
              count_r <= '0;
              state_r <= ST_COLLECT;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_COLLECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      for (int i = 0; i < ssel_pkg::MAX_PER_LINE; i++) begin
        list_r[i] <= list_nxt[i];
      end
    end
    if (state_r == ST_EMIT && out_free) begin
      found_r <= (count_r != '0);
      last_r  <= emit_last;
      // empty scan reports all-zero fields
      out_ent_r <= (count_r != '0) ? emit_ent : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.out_y       = out_ent_r.y;
  assign out_ch.out_x       = out_ent_r.x;
  assign out_ch.out_tile    = out_ent_r.tile;
  assign out_ch.out_attr    = out_ent_r.attr;
  assign out_ch.last_result = last_r;

endmodule

// ===== design/sprite_scanline_select_core.sv =====
// A closing entry passes the queue, ST_COLLECT and ST_EMIT before its first result.
// Throughput: one entry per cycle while collecting; a scan's results (1 to 10) are
//   emitted one by one, during which the sort/emit stage takes no entries.
// The 2-entry queue takes up to two hits or closing entries while results drain.
// Reset (rst_n low at a clock edge) empties queue and selection, clears tall_sprites.
`timescale 1ns / 1ps
module sprite_scanline_select_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  ssel_in_if.sink     in_ch,
  ssel_out_if.source  out_ch
);

  logic              tall_sprites_r;
  logic              q_full;
  logic              q_push;
  logic              q_valid;
  logic              q_pop;
  ssel_pkg::q_item_t push_item;
  ssel_pkg::q_item_t pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tall_sprites_r <= 1'b0;
    end else if (cfg_we) begin
      tall_sprites_r <= cfg_wdata;
    end
  end

  ssel_front u_front (
    .in_ch        (in_ch),
    .tall_sprites (tall_sprites_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  ssel_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (q_pop),
    .pop_item  (pop_item)
  );

  ssel_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/ssel_checker.sv =====
`timescale 1ns / 1ps
module ssel_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic [7:0] out_x,
  input logic       last_result
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x))
    else $error("result changed while stalled");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> last_result)
    else $error("empty-scan result not marked last");

  a_x_ascends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_result ##1 out_valid && found |->
      out_x >= $past(out_x))
    else $error("results out of X order");

endmodule

bind sprite_scanline_select_core ssel_checker u_ssel_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.found),
  .out_x       (out_ch.out_x),
  .last_result (out_ch.last_result)
);

// ===== test/sprite_select_checker.sv =====
`timescale 1ns / 1ps
module sprite_select_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  ssel_in_if         in_mon,
  ssel_out_if        out_mon,
  output int         errors,
  output int         pending,
  output int         results_seen
);

  typedef struct packed {
    logic             found;
    ssel_pkg::entry_t ent;
    logic             last;
  } sel_result_t;

  ssel_pkg::entry_t line_sel [ssel_pkg::MAX_PER_LINE];
  int            sel_count;
  logic          tall_mode;
  sel_result_t   sel_results_q[$];
  int            n_fail = 0;
  int            n_seen = 0;

  assign errors       = n_fail;
  assign results_seen = n_seen;

  task automatic report_mismatch(input string msg);
    n_fail++;
    $display("[%0t] sprite select mismatch: %s", $time, msg);
  endtask

  // insertion keeps ascending X; equal X stays in arrival order
  task automatic collect_sprite(input ssel_pkg::entry_t e, input logic [7:0] scan_ln,
                                input logic last);
    logic [8:0]  probe;
    logic [8:0]  bottom;
    sel_result_t r;
    int          pos;
    probe  = {1'b0, scan_ln} + ssel_pkg::LINE_OFFSET;
    bottom = {1'b0, e.y} + (tall_mode ? ssel_pkg::HEIGHT_TALL : ssel_pkg::HEIGHT_SHORT);
    if (probe >= {1'b0, e.y} && probe < bottom && sel_count < ssel_pkg::MAX_PER_LINE) begin
      pos = sel_count;
      while (pos > 0 && line_sel[pos-1].x > e.x) begin
        line_sel[pos] = line_sel[pos-1];
        pos--;
      end
      line_sel[pos] = e;
      sel_count++;
    end
    if (last) begin
      if (sel_count == 0) begin
        r = '{found: 1'b0, ent: '0, last: 1'b1};
        sel_results_q.insert(sel_results_q.size(), r);
      end else begin
        for (int i = 0; i < sel_count; i++) begin
          r = '{found: 1'b1, ent: line_sel[i], last: (i == sel_count - 1)};
          sel_results_q.insert(sel_results_q.size(), r);
        end
      end
      sel_count = 0;
    end
  endtask

  task automatic check_result();
    sel_result_t want;
    n_seen++;
    if (sel_results_q.size() == 0) begin
      report_mismatch("result transaction with nothing expected");
    end else begin
      want = sel_results_q.pop_front();
      if (out_mon.found !== want.found)
        report_mismatch($sformatf("found %0b, expected %0b", out_mon.found, want.found));
      if (out_mon.out_y !== want.ent.y)
        report_mismatch($sformatf("out_y %0d, expected %0d", out_mon.out_y, want.ent.y));
      if (out_mon.out_x !== want.ent.x)
        report_mismatch($sformatf("out_x %0d, expected %0d", out_mon.out_x, want.ent.x));
      if (out_mon.out_tile !== want.ent.tile)
        report_mismatch($sformatf("out_tile %0d, expected %0d", out_mon.out_tile,
                                  want.ent.tile));
      if (out_mon.out_attr !== want.ent.attr)
        report_mismatch($sformatf("out_attr %0d, expected %0d", out_mon.out_attr,
                                  want.ent.attr));
      if (out_mon.last_result !== want.last)
        report_mismatch($sformatf("last_result %0b, expected %0b", out_mon.last_result,
                                  want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sel_count = 0;
      tall_mode = 1'b0;
      sel_results_q.delete();
    end else begin
      if (cfg_we)
        tall_mode = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        collect_sprite('{attr: in_mon.attribute_bits, tile: in_mon.tile_number,
                         x: in_mon.sprite_x, y: in_mon.sprite_y},
                       in_mon.scan_line, in_mon.last_entry);
      if (out_mon.valid && out_mon.ready)
        check_result();
    end
    pending <= sel_results_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_ITEMS        = 420;
  localparam int CALM_TAIL      = 60;
  localparam int PHASE_ITEMS    = 100;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ssel_in_if  in_ch ();
  ssel_out_if out_ch ();

  int   errors;
  int   pending;
  int   results_seen;
  bit   idle_on = 1'b1;
  bit   calm_scan = 1'b0;
  logic tall_now = 1'b0;
  int   n_items = 0;
  int   n_scans = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  always #6 clk = ~clk;

  sprite_scanline_select_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sprite_select_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // result side backpressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_entry(input logic [7:0] y, input logic [7:0] x, input logic [7:0] tile,
                            input logic [7:0] attr, input logic [7:0] scan_ln,
                            input logic last);
    if (idle_on && !calm_scan && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sprite_y       <= y;
    in_ch.sprite_x       <= x;
    in_ch.tile_number    <= tile;
    in_ch.attribute_bits <= attr;
    in_ch.scan_line      <= scan_ln;
    in_ch.last_entry     <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
    if (last)
      n_scans++;
  endtask

  // stop sending, let every result drain, then leave room for entries still in flight
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tall(input logic v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tall_now  = v;
  endtask

  task automatic random_scan();
    int         len;
    int         height;
    int         hi_y;
    int         r;
    logic [7:0] scan_ln;
    logic [7:0] y_v;
    logic [7:0] x_v;
    logic [7:0] ln_v;
    logic       last_v;
    len       = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 14);
    scan_ln   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(154, 255))
                                            : 8'($urandom_range(0, 153));
    height    = tall_now ? 16 : 8;
    calm_scan = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      r    = $urandom_range(0, 9);
      ln_v = scan_ln;
      if (r < 6)
        hi_y = int'(scan_ln) + 16 - int'($urandom_range(0, height - 1));
      else if (r == 6)
        hi_y = int'(scan_ln) + 16 - height;   // just past the sprite bottom
      else if (r == 7)
        hi_y = int'(scan_ln) + 17;            // sprite starts below the line
      else
        hi_y = 256;
      y_v = (hi_y >= 0 && hi_y <= 255) ? 8'(hi_y) : 8'($urandom);
      x_v = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
      if (r == 9)
        ln_v = 8'($urandom);
      // an early close now and then breaks a scan short
      last_v = (k == len - 1) || ($urandom_range(0, 59) == 0);
      send_entry(y_v, x_v, 8'($urandom), 8'($urandom), ln_v, last_v);
    end
    calm_scan = 1'b0;
  endtask

  initial begin
    int next_switch;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.sprite_y       <= '0;
    in_ch.sprite_x       <= '0;
    in_ch.tile_number    <= '0;
    in_ch.attribute_bits <= '0;
    in_ch.scan_line      <= '0;
    in_ch.last_entry     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // short sprites, line 0: edges of the covered range and an X tie
    set_tall(1'b0);
    send_entry(8'd16, 8'd255, 8'd0,   8'd255, 8'd0, 1'b0);
    send_entry(8'd9,  8'd0,   8'd255, 8'd0,   8'd0, 1'b0);
    send_entry(8'd8,  8'd5,   8'd1,   8'd1,   8'd0, 1'b0);
    send_entry(8'd17, 8'd6,   8'd2,   8'd2,   8'd0, 1'b0);
    send_entry(8'd12, 8'd0,   8'd3,   8'd3,   8'd0, 1'b1);
    // nothing on the line
    send_entry(8'd0,  8'd77,  8'd4,   8'd4,   8'd100, 1'b1);
    // twelve hits, descending X in pairs: the last two are dropped
    for (int k = 0; k < 12; k++)
      send_entry(8'd60, 8'(200 - (k / 2) * 30), 8'(k), 8'(8'hA0 + k), 8'd50, k == 11);

    // tall sprites with the scan line above the visible range
    set_tall(1'b1);
    send_entry(8'd255, 8'd10, 8'd20, 8'd30, 8'd255, 1'b1);
    send_entry(8'd255, 8'd40, 8'd21, 8'd31, 8'd240, 1'b0);
    send_entry(8'd241, 8'd40, 8'd22, 8'd32, 8'd240, 1'b0);
    send_entry(8'd240, 8'd39, 8'd23, 8'd33, 8'd240, 1'b1);

    next_switch = n_items + PHASE_ITEMS;
    while (n_items < N_ITEMS) begin
      random_scan();
      if (n_items >= N_ITEMS - CALM_TAIL)
        idle_on = 1'b0;
      if (n_items >= next_switch && n_items < N_ITEMS) begin
        set_tall(~tall_now);
        next_switch = n_items + PHASE_ITEMS;
      end
    end

    drain_results();
    repeat (12) @(posedge clk);
    $display("summary: %0d sprite entries over %0d scans, %0d results checked,",
             n_items, n_scans, results_seen);
    $display("summary: short and tall sprites, empty and overfull lines, X ties");
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
